// ===== design/plbbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbbc_pkg: shared types and constants for the pinned LRU byte budget cache
// Command and status codes, sequencer states, default sizes.
// ----------------------------------------------------------------------------
package plbbc_pkg;

    localparam int DefaultEntries  = 16;
    localparam int KeyW            = 32;
    localparam int BytesW          = 24;
    localparam int TotalW          = 28;
    localparam int PinW            = 8;
    localparam logic [PinW-1:0] PinMax = 8'd255;
    localparam logic [TotalW-1:0] CapReset = 28'd1048576;

    typedef enum logic [1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_SET     = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_ABSENT   = 3'd2,
        ST_UNPINNED = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_EVCHK,
        S_EVICT,
        S_EVOUT,
        S_DONE
    } state_t;

endpackage

// ===== design/pinned_lru_byte_budget_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinned_lru_byte_budget_cache: keyed cache table with pins, LRU and budget
// Sequenced controller over a small slot table with a linked recency list.
// ----------------------------------------------------------------------------
// Usage: an item (cmd, key, size_bytes) is taken when in_valid is high and
// in_stall is low; in_stall stays high while an item is in work. Each item
// walks one shared key comparator across the slots, one slot per cycle. The
// status item is loaded after the scan, the execute step and the eviction
// check; the next item can be taken once it is loaded. Each eviction passes
// S_EVICT and S_EVOUT, and out_stall on a pending result delays a load.
// After a set or an unpinning release, evictions pull from the back of the
// recency list, one result each, while total bytes exceed capacity_bytes;
// a final status item with last = 1 closes every command.
// capacity_bytes is written through cfg_valid/cfg_ready while idle.
// used_bytes saturates at 2^28-1 when the exact total grows beyond it.
// ----------------------------------------------------------------------------
module pinned_lru_byte_budget_cache #(
    parameter int ENTRIES = plbbc_pkg::DefaultEntries
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [27:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [31:0] key,
    input  logic [23:0] size_bytes,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        hit,
    output logic        evicted,
    output logic [31:0] evicted_key,
    output logic [27:0] used_bytes,
    output logic        last
);

    localparam int IW   = $clog2(ENTRIES + 1);     // slot index incl. "none"
    localparam int TOTW = plbbc_pkg::TotalW + 6;   // exact total, no wrap
    localparam logic [IW-1:0] NoSlot = IW'(ENTRIES);
    localparam logic [TOTW-1:0] TotSat = {{6{1'b0}}, {plbbc_pkg::TotalW{1'b1}}};

    // slot table (flops; valid and list bits reset, payload does not)
    logic [ENTRIES-1:0]           valid_reg, inlist_reg;
    logic [plbbc_pkg::KeyW-1:0]   skey_reg  [ENTRIES];
    logic [plbbc_pkg::PinW-1:0]   pin_reg   [ENTRIES];
    logic [plbbc_pkg::BytesW-1:0] sbytes_reg[ENTRIES];
    logic [IW-1:0]                newer_reg [ENTRIES];
    logic [IW-1:0]                older_reg [ENTRIES];
    logic [IW-1:0]                front_reg, back_reg;
    logic [TOTW-1:0]              total_reg;
    logic [plbbc_pkg::TotalW-1:0] cap_reg;

    plbbc_pkg::state_t state_reg, state_next;
    logic [1:0]                   cmd_reg;
    logic [plbbc_pkg::KeyW-1:0]   key_reg;
    logic [plbbc_pkg::BytesW-1:0] nb_reg;
    logic [IW-1:0]                idx_reg;     // scan counter
    logic [IW-1:0]                match_reg;   // matching slot
    logic [IW-1:0]                free_reg;    // lowest free slot
    logic [IW-1:0]                vict_reg;
    logic [2:0]                   st_reg;
    logic                         hit_reg;
    logic                         evict_en_reg;

    logic                         ov_reg, oev_reg, olast_reg, ohit_reg;
    logic [2:0]                   ost_reg;
    logic [plbbc_pkg::KeyW-1:0]   oekey_reg;
    logic [plbbc_pkg::TotalW-1:0] oused_reg;

    logic [$clog2(ENTRIES)-1:0] ix, mx, vx;
    logic out_free, scan_last, key_eq, load_out;

    assign ix  = idx_reg[$clog2(ENTRIES)-1:0];
    assign mx  = match_reg[$clog2(ENTRIES)-1:0];
    assign vx  = vict_reg[$clog2(ENTRIES)-1:0];
    assign out_free  = !ov_reg || !out_stall;
    assign scan_last = (idx_reg == IW'(ENTRIES - 1));
    // the shared comparator
    assign key_eq = valid_reg[ix] && (skey_reg[ix] == key_reg);
    // output register takes a new result this cycle
    assign load_out = out_free && ((state_reg == plbbc_pkg::S_EVOUT) ||
                                   (state_reg == plbbc_pkg::S_DONE));

    assign in_stall  = (state_reg != plbbc_pkg::S_IDLE);
    assign cfg_ready = (state_reg == plbbc_pkg::S_IDLE) && !ov_reg;

    assign out_valid   = ov_reg;
    assign status      = ost_reg;
    assign hit         = ohit_reg;
    assign evicted     = oev_reg;
    assign evicted_key = oekey_reg;
    assign used_bytes  = oused_reg;
    assign last        = olast_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plbbc_pkg::S_IDLE:  if (in_valid) state_next = plbbc_pkg::S_SCAN;
            plbbc_pkg::S_SCAN:  if (scan_last) state_next = plbbc_pkg::S_EXEC;
            plbbc_pkg::S_EXEC:  state_next = plbbc_pkg::S_EVCHK;
            plbbc_pkg::S_EVCHK:
                if (evict_en_reg && (total_reg > TOTW'(cap_reg)) && (back_reg != NoSlot))
                    state_next = plbbc_pkg::S_EVICT;
                else
                    state_next = plbbc_pkg::S_DONE;
            plbbc_pkg::S_EVICT: state_next = plbbc_pkg::S_EVOUT;
            plbbc_pkg::S_EVOUT: if (out_free) state_next = plbbc_pkg::S_EVCHK;
            plbbc_pkg::S_DONE:  if (out_free) state_next = plbbc_pkg::S_IDLE;
            default:            state_next = plbbc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= plbbc_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    function automatic logic [TOTW-1:0] sub_sat(input logic [TOTW-1:0] a,
                                                input logic [TOTW-1:0] b);
        return (a >= b) ? (a - b) : '0;
    endfunction

    // datapath and table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            inlist_reg   <= '0;
            front_reg    <= NoSlot;
            back_reg     <= NoSlot;
            total_reg    <= '0;
            cap_reg      <= plbbc_pkg::CapReset;
            ov_reg       <= 1'b0;
            idx_reg      <= '0;
            match_reg    <= NoSlot;
            free_reg     <= NoSlot;
            evict_en_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= load_out || (ov_reg && out_stall);
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            case (state_reg)
                plbbc_pkg::S_IDLE:
                    if (in_valid)
                    begin
                        cmd_reg      <= cmd;
                        key_reg      <= key;
                        nb_reg       <= size_bytes;
                        idx_reg      <= '0;
                        match_reg    <= NoSlot;
                        free_reg     <= NoSlot;
                        evict_en_reg <= 1'b0;
                    end
                plbbc_pkg::S_SCAN:
                begin
                    if (key_eq && match_reg == NoSlot)
                        match_reg <= idx_reg;
                    if (!valid_reg[ix] && free_reg == NoSlot)
                        free_reg <= idx_reg;
                    idx_reg <= idx_reg + 1'b1;
                end
                plbbc_pkg::S_EXEC:
                begin
                    case (cmd_reg)
                        plbbc_pkg::CMD_ACQUIRE:
                        begin
                            hit_reg <= (match_reg != NoSlot);
                            if (match_reg != NoSlot)
                            begin
                                if (pin_reg[mx] == plbbc_pkg::PinMax)
                                    st_reg <= plbbc_pkg::ST_OVERFLOW;
                                else
                                begin
                                    st_reg      <= plbbc_pkg::ST_OK;
                                    pin_reg[mx] <= pin_reg[mx] + 1'b1;
                                    if (pin_reg[mx] == '0 && inlist_reg[mx])
                                    begin
                                        // unlink
                                        if (newer_reg[mx] != NoSlot)
                                            older_reg[newer_reg[mx][$clog2(ENTRIES)-1:0]]
                                                <= older_reg[mx];
                                        else
                                            front_reg <= older_reg[mx];
                                        if (older_reg[mx] != NoSlot)
                                            newer_reg[older_reg[mx][$clog2(ENTRIES)-1:0]]
                                                <= newer_reg[mx];
                                        else
                                            back_reg <= newer_reg[mx];
                                        inlist_reg[mx] <= 1'b0;
                                    end
                                end
                            end
                            else if (free_reg == NoSlot)
                                st_reg <= plbbc_pkg::ST_FULL;
                            else
                            begin
                                st_reg <= plbbc_pkg::ST_OK;
                                valid_reg[free_reg[$clog2(ENTRIES)-1:0]]  <= 1'b1;
                                skey_reg[free_reg[$clog2(ENTRIES)-1:0]]   <= key_reg;
                                pin_reg[free_reg[$clog2(ENTRIES)-1:0]]    <= 8'd1;
                                sbytes_reg[free_reg[$clog2(ENTRIES)-1:0]] <= '0;
                                inlist_reg[free_reg[$clog2(ENTRIES)-1:0]] <= 1'b0;
                            end
                        end
                        plbbc_pkg::CMD_RELEASE,
                        plbbc_pkg::CMD_SET:
                        begin
                            hit_reg <= 1'b0;
                            if (match_reg == NoSlot)
                                st_reg <= plbbc_pkg::ST_ABSENT;
                            else if (pin_reg[mx] == '0)
                                st_reg <= plbbc_pkg::ST_UNPINNED;
                            else if (cmd_reg == plbbc_pkg::CMD_RELEASE)
                            begin
                                st_reg      <= plbbc_pkg::ST_OK;
                                pin_reg[mx] <= pin_reg[mx] - 1'b1;
                                if (pin_reg[mx] == 8'd1 && !inlist_reg[mx])
                                begin
                                    // link at front
                                    older_reg[mx]  <= front_reg;
                                    newer_reg[mx]  <= NoSlot;
                                    if (front_reg != NoSlot)
                                        newer_reg[front_reg[$clog2(ENTRIES)-1:0]] <= match_reg;
                                    else
                                        back_reg <= match_reg;
                                    front_reg      <= match_reg;
                                    inlist_reg[mx] <= 1'b1;
                                    evict_en_reg   <= 1'b1;
                                end
                                else if (pin_reg[mx] == 8'd1)
                                    evict_en_reg <= 1'b1;
                            end
                            else
                            begin
                                st_reg <= plbbc_pkg::ST_OK;
                                if (nb_reg >= sbytes_reg[mx])
                                    total_reg <= total_reg + TOTW'(nb_reg - sbytes_reg[mx]);
                                else
                                    total_reg <= sub_sat(total_reg,
                                                         TOTW'(sbytes_reg[mx] - nb_reg));
                                sbytes_reg[mx] <= nb_reg;
                                evict_en_reg   <= 1'b1;
                            end
                        end
                        default:
                        begin
                            st_reg  <= plbbc_pkg::ST_OK;
                            hit_reg <= 1'b0;
                        end
                    endcase
                end
                plbbc_pkg::S_EVCHK:
                    vict_reg <= back_reg;
                plbbc_pkg::S_EVICT:
                begin
                    if (newer_reg[vx] != NoSlot)
                        older_reg[newer_reg[vx][$clog2(ENTRIES)-1:0]] <= older_reg[vx];
                    else
                        front_reg <= older_reg[vx];
                    if (older_reg[vx] != NoSlot)
                        newer_reg[older_reg[vx][$clog2(ENTRIES)-1:0]] <= newer_reg[vx];
                    else
                        back_reg <= newer_reg[vx];
                    inlist_reg[vx] <= 1'b0;
                    valid_reg[vx]  <= 1'b0;
                    total_reg      <= sub_sat(total_reg, TOTW'(sbytes_reg[vx]));
                end
                plbbc_pkg::S_EVOUT:
                    if (out_free)
                    begin
                        ost_reg   <= plbbc_pkg::ST_OK;
                        ohit_reg  <= 1'b0;
                        oev_reg   <= 1'b1;
                        oekey_reg <= skey_reg[vx];
                        olast_reg <= 1'b0;
                        oused_reg <= (total_reg > TotSat) ? TotSat[27:0] : total_reg[27:0];
                    end
                plbbc_pkg::S_DONE:
                    if (out_free)
                    begin
                        ost_reg   <= st_reg;
                        ohit_reg  <= hit_reg;
                        oev_reg   <= 1'b0;
                        oekey_reg <= '0;
                        olast_reg <= 1'b1;
                        oused_reg <= (total_reg > TotSat) ? TotSat[27:0] : total_reg[27:0];
                    end
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    a_front_back_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (front_reg == NoSlot) == (back_reg == NoSlot))
        else $error("list front/back disagree");
    a_list_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (inlist_reg & ~valid_reg) == '0)
        else $error("listed slot not valid");
    a_last_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> !(olast_reg && oev_reg))
        else $error("eviction marked last");
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plbbc_pkg::S_EVICT) |=> (state_reg == plbbc_pkg::S_EVOUT))
        else $error("eviction sequence broken");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for pinned_lru_byte_budget_cache
// Drives acquire/release/set_bytes and unknown-command items and checks every status and eviction
// item against a cycle-free model of the slot table, its pin counts, the
// recency list and the byte budget, across several capacity settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int NSLOT = plbbc_pkg::DefaultEntries;
    localparam int NO_SLOT = NSLOT;
    localparam int LIMIT = 1_000_000;
    localparam logic [plbbc_pkg::TotalW-1:0] TOTAL_SAT = '1;

    typedef struct {
        plbbc_pkg::cmd_t              op;
        logic [plbbc_pkg::KeyW-1:0]   k;
        logic [plbbc_pkg::BytesW-1:0] nb;
    } cache_op_t;

    typedef struct {
        logic [2:0]                   st;
        logic                         hit;
        logic                         ev;
        logic [plbbc_pkg::KeyW-1:0]   ek;
        logic [plbbc_pkg::TotalW-1:0] used;
        logic                         last;
    } cache_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [27:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] cmd = '0;
    logic [31:0] key = '0;
    logic [23:0] size_bytes = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] status;
    logic hit;
    logic evicted;
    logic [31:0] evicted_key;
    logic [27:0] used_bytes;
    logic last;

    pinned_lru_byte_budget_cache u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .key(key), .size_bytes(size_bytes),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .hit(hit), .evicted(evicted),
        .evicted_key(evicted_key), .used_bytes(used_bytes), .last(last)
    );

    // model of the cache contents
    bit                         m_valid [NSLOT];
    logic [plbbc_pkg::KeyW-1:0] m_key   [NSLOT];
    int                         m_pins  [NSLOT];
    int                         m_bytes [NSLOT];
    bit                         m_linked[NSLOT];
    int                         m_newer [NSLOT];
    int                         m_older [NSLOT];
    int                         m_front = NO_SLOT;
    int                         m_back = NO_SLOT;
    longint                     m_total = 0;
    longint                     m_cap = plbbc_pkg::CapReset;

    cache_op_t  op_q[$];      // items waiting for the driver
    cache_res_t want_q[$];    // results the block still owes
    cache_op_t  cur;

    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_evict = 0;
    int n_caps = 0;
    int cycles = 0;
    int send_gap = 0;
    int stall_left = 0;
    logic hold = 1'b0;
    bit hold_arm = 1'b0;
    logic [plbbc_pkg::KeyW-1:0] pool[20];

    initial forever #5 clk = ~clk;

    // --------------------------------------------------------------------
    // Model
    // --------------------------------------------------------------------
    function automatic void push_res(logic [2:0] st, logic h, logic ev,
                                     logic [plbbc_pkg::KeyW-1:0] ek, logic lst);
        cache_res_t r;
        r.st = st;
        r.hit = h;
        r.ev = ev;
        r.ek = ek;
        r.used = (m_total > longint'(TOTAL_SAT)) ? TOTAL_SAT
                                                 : m_total[plbbc_pkg::TotalW-1:0];
        r.last = lst;
        want_q.push_back(r);
    endfunction

    function automatic int find_key(logic [plbbc_pkg::KeyW-1:0] k);
        for (int i = 0; i < NSLOT; i++)
            if (m_valid[i] && m_key[i] == k)
                return i;
        return NO_SLOT;
    endfunction

    function automatic void list_remove(int e);
        int n;
        int o;
        if (!m_linked[e])
            return;
        n = m_newer[e];
        o = m_older[e];
        if (n < NSLOT) m_older[n] = o; else m_front = o;
        if (o < NSLOT) m_newer[o] = n; else m_back = n;
        m_linked[e] = 1'b0;
    endfunction

    function automatic void list_push_front(int e);
        if (m_linked[e])
            return;
        m_older[e] = m_front;
        m_newer[e] = NO_SLOT;
        if (m_front < NSLOT) m_newer[m_front] = e; else m_back = e;
        m_front = e;
        m_linked[e] = 1'b1;
    endfunction

    // drop least recently used entries while over budget
    function automatic void trim_to_budget();
        int v;
        while (m_total > m_cap && m_back < NSLOT) begin
            v = m_back;
            list_remove(v);
            m_total -= (m_total >= m_bytes[v]) ? m_bytes[v] : m_total;
            m_valid[v] = 1'b0;
            push_res(plbbc_pkg::ST_OK, 1'b0, 1'b1, m_key[v], 1'b0);
        end
    endfunction

    function automatic void cache_predict(cache_op_t it);
        int s;
        int f;
        s = find_key(it.k);
        case (it.op)
            plbbc_pkg::CMD_ACQUIRE: begin
                if (s < NSLOT) begin
                    if (m_pins[s] >= plbbc_pkg::PinMax) begin
                        push_res(plbbc_pkg::ST_OVERFLOW, 1'b1, 1'b0, '0, 1'b1);
                        return;
                    end
                    if (m_pins[s] == 0)
                        list_remove(s);
                    m_pins[s]++;
                    push_res(plbbc_pkg::ST_OK, 1'b1, 1'b0, '0, 1'b1);
                    return;
                end
                f = NO_SLOT;
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (!m_valid[i])
                        f = i;
                if (f == NO_SLOT) begin
                    push_res(plbbc_pkg::ST_FULL, 1'b0, 1'b0, '0, 1'b1);
                    return;
                end
                m_valid[f] = 1'b1;
                m_key[f] = it.k;
                m_pins[f] = 1;
                m_bytes[f] = 0;
                m_linked[f] = 1'b0;
                push_res(plbbc_pkg::ST_OK, 1'b0, 1'b0, '0, 1'b1);
            end
            plbbc_pkg::CMD_RELEASE, plbbc_pkg::CMD_SET: begin
                if (s == NO_SLOT) begin
                    push_res(plbbc_pkg::ST_ABSENT, 1'b0, 1'b0, '0, 1'b1);
                    return;
                end
                if (m_pins[s] == 0) begin
                    push_res(plbbc_pkg::ST_UNPINNED, 1'b0, 1'b0, '0, 1'b1);
                    return;
                end
                if (it.op == plbbc_pkg::CMD_RELEASE) begin
                    m_pins[s]--;
                    if (m_pins[s] == 0) begin
                        list_push_front(s);
                        trim_to_budget();
                    end
                end else begin
                    if (int'(it.nb) >= m_bytes[s])
                        m_total += int'(it.nb) - m_bytes[s];
                    else
                        m_total -= (m_total >= m_bytes[s] - int'(it.nb)) ?
                                   m_bytes[s] - int'(it.nb) : m_total;
                    m_bytes[s] = int'(it.nb);
                    trim_to_budget();
                end
                push_res(plbbc_pkg::ST_OK, 1'b0, 1'b0, '0, 1'b1);
            end
            default: push_res(plbbc_pkg::ST_OK, 1'b0, 1'b0, '0, 1'b1);
        endcase
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // --------------------------------------------------------------------
    // Driver: one item in flight on the input port; payload holds while stalled
    // --------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                cache_predict(cur);
                n_items++;
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (op_q.size() > 0) begin
                    cur = op_q.pop_front();
                    cmd <= cur.op;
                    key <= cur.k;
                    size_bytes <= cur.nb;
                    in_valid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // --------------------------------------------------------------------
    // Monitor: random output stalls plus the long hold-off, then compare
    // --------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        int nxt;
        cache_res_t w;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                n_results++;
                if (evicted)
                    n_evict++;
                if (want_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: status %0d evicted %0b key %h",
                                 status, evicted, evicted_key);
                end else begin
                    w = want_q.pop_front();
                    if (status !== w.st || hit !== w.hit || evicted !== w.ev ||
                        evicted_key !== w.ek || used_bytes !== w.used ||
                        last !== w.last) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp st %0d hit %0b ev %0b key %h used %0d ",
                                      "last %0b / got st %0d hit %0b ev %0b key %h used %0d ",
                                      "last %0b"},
                                     w.st, w.hit, w.ev, w.ek, w.used, w.last,
                                     status, hit, evicted, evicted_key, used_bytes, last);
                    end
                end
            end
            if (stall_left > 0)
                nxt = stall_left - 1;
            else if ($urandom_range(0, 3) == 0)
                nxt = pick_gap();
            else
                nxt = 0;
            stall_left <= nxt;
            out_stall <= hold || (nxt != 0);
        end
    end

    // long receiver hold-off once the random traffic is running
    initial begin
        wait (hold_arm);
        repeat (150) @(posedge clk);
        hold <= 1'b1;
        repeat (600) @(posedge clk);
        hold <= 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // --------------------------------------------------------------------
    // Stimulus
    // --------------------------------------------------------------------
    task automatic add(plbbc_pkg::cmd_t op, logic [plbbc_pkg::KeyW-1:0] k,
                       logic [plbbc_pkg::BytesW-1:0] nb);
        cache_op_t it;
        it.op = op;
        it.k = k;
        it.nb = nb;
        op_q.push_back(it);
    endtask

    task automatic wait_drained();
        wait (op_q.size() == 0 && !in_valid && want_q.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_capacity(logic [27:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        m_cap = v;
        n_caps++;
    endtask

    function automatic logic [plbbc_pkg::BytesW-1:0] rand_size();
        if ($urandom_range(0, 7) == 0)
            return plbbc_pkg::BytesW'($urandom);
        return plbbc_pkg::BytesW'($urandom_range(0, 3_000_000));
    endfunction

    // well-formed pin/size/unpin sequences with some noise mixed in
    task automatic random_traffic(int count);
        logic [plbbc_pkg::KeyW-1:0] k;
        int added;
        added = 0;
        while (added < count) begin
            k = pool[$urandom_range(0, 19)];
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    add(plbbc_pkg::CMD_ACQUIRE, k, rand_size());
                    add(plbbc_pkg::CMD_SET, k, rand_size());
                    add(plbbc_pkg::CMD_RELEASE, k, rand_size());
                    added += 3;
                end
                4, 5: begin
                    add(plbbc_pkg::CMD_ACQUIRE, k, '0);
                    add(plbbc_pkg::CMD_ACQUIRE, k, '0);
                    add(plbbc_pkg::CMD_SET, k, rand_size());
                    add(plbbc_pkg::CMD_RELEASE, k, '0);
                    add(plbbc_pkg::CMD_SET, k, rand_size());
                    add(plbbc_pkg::CMD_RELEASE, k, '0);
                    added += 6;
                end
                6: begin
                    add(plbbc_pkg::CMD_ACQUIRE, k, rand_size());
                    added++;
                end
                7: begin
                    add(plbbc_pkg::CMD_RELEASE, k, rand_size());
                    added++;
                end
                8: begin
                    add(plbbc_pkg::CMD_SET, $urandom, rand_size());
                    added++;
                end
                default: begin
                    add(plbbc_pkg::CMD_NONE, $urandom, rand_size());
                    added++;
                end
            endcase
        end
    endtask

    initial begin
        for (int i = 0; i < 20; i++)
            pool[i] = $urandom;
        pool[0] = '0;
        pool[1] = '1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_capacity(plbbc_pkg::CapReset);

        // directed: extremes, hits, absent, unpinned, unknown command,
        // eviction stopping at an empty list while pinned bytes stay over
        @(negedge clk);
        add(plbbc_pkg::CMD_ACQUIRE, 32'h0, '0);
        add(plbbc_pkg::CMD_ACQUIRE, 32'hFFFF_FFFF, '0);
        add(plbbc_pkg::CMD_ACQUIRE, 32'h0, '0);
        add(plbbc_pkg::CMD_SET, 32'h0, 24'hFF_FFFF);
        add(plbbc_pkg::CMD_SET, 32'hFFFF_FFFF, 24'd600000);
        add(plbbc_pkg::CMD_RELEASE, 32'hFFFF_FFFF, '0);
        add(plbbc_pkg::CMD_RELEASE, 32'hFFFF_FFFF, '0);
        add(plbbc_pkg::CMD_RELEASE, 32'h0, '0);
        add(plbbc_pkg::CMD_RELEASE, 32'h0, '0);
        add(plbbc_pkg::CMD_ACQUIRE, 32'h1234_5678, '0);
        add(plbbc_pkg::CMD_RELEASE, 32'h1234_5678, '0);
        add(plbbc_pkg::CMD_RELEASE, 32'h1234_5678, '0);
        add(plbbc_pkg::CMD_SET, 32'h1234_5678, 24'd5);
        add(plbbc_pkg::CMD_NONE, 32'hA5A5_A5A5, 24'hFF_FFFF);
        add(plbbc_pkg::CMD_SET, 32'hDEAD_BEEF, 24'd7);
        add(plbbc_pkg::CMD_ACQUIRE, 32'h1234_5678, '0);
        wait_drained();

        // fill the table, hit the full case, then release into evictions
        @(negedge clk);
        for (int i = 0; i < NSLOT; i++) begin
            add(plbbc_pkg::CMD_ACQUIRE, 32'h100 + i, '0);
            add(plbbc_pkg::CMD_SET, 32'h100 + i, 24'd70000);
        end
        add(plbbc_pkg::CMD_ACQUIRE, 32'h8000_0000, '0);
        for (int i = 0; i < NSLOT; i++)
            add(plbbc_pkg::CMD_RELEASE, 32'h100 + i, '0);
        add(plbbc_pkg::CMD_RELEASE, 32'h1234_5678, '0);
        wait_drained();

        // random traffic over the capacity extremes, a middle setting and a capacity of one byte
        write_capacity(28'd0);
        @(negedge clk);
        hold_arm = 1'b1;
        random_traffic(28);
        wait_drained();
        write_capacity(28'hFFF_FFFF);
        @(negedge clk);
        random_traffic(28);
        wait_drained();
        write_capacity(28'd4_000_000);
        @(negedge clk);
        random_traffic(28);
        wait_drained();
        write_capacity(28'd1);
        @(negedge clk);
        random_traffic(28);
        wait_drained();

        errors += want_q.size();
        $display("covered %0d items, %0d results (%0d evictions), %0d capacity writes",
                 n_items, n_results, n_evict, n_caps);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
